FILE: hdl/dpa_pkg.sv
// Shared types and constants for the double-ended pool allocator.
`timescale 1ns / 1ps

package dpa_pkg;

	localparam int BANK_COUNT  = 2;
	localparam int POOL_IDX_W  = 4;
	localparam int unsigned STAGE_POOL = 4;
	localparam int unsigned PERM_POOL  = 6;

	localparam logic [31:0] EXP_BASE  = 32'h8040_0000;
	localparam logic [31:0] KSEG_BASE = 32'h8000_0000;
	localparam logic [23:0] FOUR_MIB  = 24'h40_0000;

	typedef enum logic [2:0] {
		OP_INIT        = 3'd0,
		OP_ALLOC_LEFT  = 3'd1,
		OP_ALLOC_RIGHT = 3'd2,
		OP_RESIZE      = 3'd3,
		OP_RESET_POOL  = 3'd4,
		OP_DISABLE     = 3'd5,
		OP_FREE_QUERY  = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_HEAP_START  = 2'd0,
		CFG_HEAP_LENGTH = 2'd1,
		CFG_MEMORY_SIZE = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [2:0]            opcode;
		logic [POOL_IDX_W-1:0] pool_index;
		logic                  bank_select;
		logic [31:0]           byte_count;
		logic [31:0]           block_address;
	} command_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic        status;
		logic [31:0] free_bytes;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} dpa_ctl_t;

endpackage

FILE: hdl/dpa_ctrl.sv
// Command sequencer: capture cycle, execute cycle, result strobe.
`timescale 1ns / 1ps

module dpa_ctrl import dpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dpa_ctl_t ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy        = (state_q == ST_EXEC);
	assign done        = done_q;
	assign ctl.capture = start && (state_q == ST_IDLE);
	assign ctl.execute = (state_q == ST_EXEC);

endmodule

FILE: hdl/dpa_datapath.sv
// Pool tables, config registers, operand capture and the allocate/resize logic.
`timescale 1ns / 1ps

module dpa_datapath import dpa_pkg::*; #(
	parameter int POOL_COUNT = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dpa_ctl_t    ctl,
	input  command_t    command,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output result_t     result
);

	localparam int IDX_W = $clog2(POOL_COUNT);
	localparam logic [IDX_W-1:0] STAGE_IDX = IDX_W'(STAGE_POOL);
	localparam logic [IDX_W-1:0] PERM_IDX  = IDX_W'(PERM_POOL);
	localparam logic [POOL_IDX_W:0] POOL_LIMIT = (POOL_IDX_W+1)'(POOL_COUNT);

	// configuration
	logic [31:0] heap_start_q;
	logic [23:0] heap_length_q;
	logic [23:0] memory_size_q;

	// pool tables, [bank][pool]
	logic [31:0] start_q [BANK_COUNT][POOL_COUNT];
	logic [31:0] left_q  [BANK_COUNT][POOL_COUNT];
	logic [31:0] right_q [BANK_COUNT][POOL_COUNT];
	logic [31:0] end_q   [BANK_COUNT][POOL_COUNT];
	logic [31:0] last_q  [BANK_COUNT][POOL_COUNT];

	// captured operands
	opcode_t          op_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             in_range_s1;
	logic             bank_s1;
	logic [31:0]      count_s1;
	logic [31:0]      blk_s1;
	logic [31:0]      perm_left_s1;
	logic [31:0]      start_s1 [BANK_COUNT];
	logic [31:0]      left_s1  [BANK_COUNT];
	logic [31:0]      right_s1 [BANK_COUNT];
	logic [31:0]      end_s1   [BANK_COUNT];
	logic [31:0]      last_s1  [BANK_COUNT];
	logic [31:0]      nl_s1    [BANK_COUNT];
	logic [31:0]      rgap_s1  [BANK_COUNT];
	logic [32:0]      lsum_s1  [BANK_COUNT];

	// execute-cycle decisions
	logic        l_ok  [BANK_COUNT];
	logic        r_ok  [BANK_COUNT];
	logic [31:0] r_new [BANK_COUNT];
	logic        wr_left  [BANK_COUNT];
	logic        wr_right [BANK_COUNT];
	logic        wr_last  [BANK_COUNT];
	logic [31:0] left_d   [BANK_COUNT];
	logic [31:0] right_d  [BANK_COUNT];
	logic        wr_stage;
	logic        do_init;
	logic        hit0, hit1, rsel;
	logic [31:0] nl_sel, grow, nl_round;
	result_t     res_d;
	result_t     result_q;

	logic [IDX_W-1:0] idx;
	logic [31:0]      heap_top;
	logic [31:0]      exp_top;

	assign idx      = command.pool_index[IDX_W-1:0];
	assign heap_top = heap_start_q + {8'd0, heap_length_q};
	assign exp_top  = KSEG_BASE + {8'd0, memory_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q  <= '0;
			heap_length_q <= '0;
			memory_size_q <= FOUR_MIB;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_HEAP_START:  heap_start_q  <= cfg_wdata;
				CFG_HEAP_LENGTH: heap_length_q <= cfg_wdata[23:0];
				CFG_MEMORY_SIZE: memory_size_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// Operand capture; sums that only need one table read are formed here.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_s1        <= opcode_t'(command.opcode);
			idx_s1       <= idx;
			in_range_s1  <= ({1'b0, command.pool_index} < POOL_LIMIT);
			bank_s1      <= command.bank_select;
			count_s1     <= command.byte_count;
			blk_s1       <= command.block_address;
			perm_left_s1 <= left_q[0][PERM_IDX];
			for (int b = 0; b < BANK_COUNT; b++) begin
				start_s1[b] <= start_q[b][idx];
				left_s1[b]  <= left_q[b][idx];
				right_s1[b] <= right_q[b][idx];
				end_s1[b]   <= end_q[b][idx];
				last_s1[b]  <= last_q[b][idx];
				nl_s1[b]    <= last_q[b][idx] + command.byte_count;
				rgap_s1[b]  <= right_q[b][idx] - left_q[b][idx];
				lsum_s1[b]  <= {1'b0, left_q[b][idx]} + {1'b0, command.byte_count};
			end
		end
	end

	always_comb begin
		for (int b = 0; b < BANK_COUNT; b++) begin
			l_ok[b]  = (left_s1[b] != '0) && (left_s1[b] <= right_s1[b]) &&
				(lsum_s1[b] <= {1'b0, right_s1[b]});
			r_ok[b]  = (right_s1[b] != '0) && (right_s1[b] >= left_s1[b]) &&
				(count_s1 <= rgap_s1[b]);
			r_new[b] = right_s1[b] - count_s1;
		end
	end

	// resize: onboard match wins, a shrink or no-op rounds up to 16 bytes
	assign hit0     = (last_s1[0] == blk_s1);
	assign hit1     = (last_s1[1] == blk_s1);
	assign rsel     = !hit0;
	assign nl_sel   = nl_s1[rsel];
	assign grow     = nl_sel - left_s1[rsel];
	assign nl_round = (nl_sel[3:0] == 4'd0) ? nl_sel : {nl_sel[31:4] + 28'd1, 4'd0};

	always_comb begin
		for (int b = 0; b < BANK_COUNT; b++) begin
			wr_left[b]  = 1'b0;
			wr_right[b] = 1'b0;
			wr_last[b]  = 1'b0;
			left_d[b]   = '0;
			right_d[b]  = '0;
		end
		wr_stage = 1'b0;
		do_init  = 1'b0;
		res_d    = '0;

		if (ctl.execute && op_s1 == OP_INIT) begin
			do_init = 1'b1;
		end else if (ctl.execute && in_range_s1) begin
			unique case (op_s1)
				OP_ALLOC_LEFT: begin
					if (l_ok[0]) begin
						wr_left[0]           = 1'b1;
						wr_last[0]           = 1'b1;
						left_d[0]            = lsum_s1[0][31:0];
						res_d.result_address = left_s1[0];
					end else if (l_ok[1]) begin
						wr_left[1]           = 1'b1;
						wr_last[1]           = 1'b1;
						left_d[1]            = lsum_s1[1][31:0];
						res_d.result_address = left_s1[1];
					end
				end
				OP_ALLOC_RIGHT: begin
					if (r_ok[0]) begin
						wr_right[0] = 1'b1;
						right_d[0]  = r_new[0];
					end
					// landing on address 0 reads as refused and falls through
					if (r_ok[0] && r_new[0] != '0) begin
						res_d.result_address = r_new[0];
					end else if (r_ok[1]) begin
						wr_right[1]          = 1'b1;
						right_d[1]           = r_new[1];
						res_d.result_address = r_new[1];
					end
				end
				OP_RESIZE: begin
					if (!hit0 && !hit1) begin
						res_d.status = 1'b1;
					end else begin
						wr_left[rsel] = 1'b1;
						left_d[rsel]  = (grow == '0 || grow[31]) ? nl_round : nl_sel;
					end
				end
				OP_RESET_POOL: begin
					for (int b = 0; b < BANK_COUNT; b++) begin
						wr_left[b] = 1'b1;
						wr_last[b] = 1'b1;
						left_d[b]  = start_s1[b];
					end
					if (idx_s1 == STAGE_IDX) begin
						wr_stage  = 1'b1;
						left_d[0] = perm_left_s1;
					end
				end
				OP_DISABLE: begin
					for (int b = 0; b < BANK_COUNT; b++) begin
						wr_left[b]  = 1'b1;
						wr_right[b] = 1'b1;
						right_d[b]  = end_s1[b];
					end
				end
				OP_FREE_QUERY: begin
					res_d.free_bytes = right_s1[bank_s1] - left_s1[bank_s1];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				for (int i = 0; i < POOL_COUNT; i++) begin
					start_q[b][i] <= '0;
					left_q[b][i]  <= '0;
					right_q[b][i] <= '0;
					end_q[b][i]   <= '0;
					last_q[b][i]  <= '0;
				end
			end
		end else if (do_init) begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				for (int i = 0; i < POOL_COUNT; i++) begin
					left_q[b][i] <= '0;
					last_q[b][i] <= '0;
					if (b == 0 && (i == 0 || i == STAGE_POOL || i == PERM_POOL)) begin
						start_q[b][i] <= heap_start_q;
						right_q[b][i] <= heap_top;
						end_q[b][i]   <= heap_top;
					end else if (b == 1 && i == STAGE_POOL && memory_size_q > FOUR_MIB) begin
						start_q[b][i] <= EXP_BASE;
						right_q[b][i] <= exp_top;
						end_q[b][i]   <= exp_top;
					end else begin
						start_q[b][i] <= '0;
						right_q[b][i] <= '0;
						end_q[b][i]   <= '0;
					end
				end
			end
		end else begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				if (wr_left[b]) begin
					left_q[b][idx_s1] <= left_d[b];
				end
				if (wr_right[b]) begin
					right_q[b][idx_s1] <= right_d[b];
				end
				if (wr_last[b]) begin
					// a left transfer records the old left; a pool reset clears it
					last_q[b][idx_s1] <= (op_s1 == OP_ALLOC_LEFT) ? left_s1[b] : '0;
				end
			end
			if (wr_stage) begin
				start_q[0][STAGE_IDX] <= perm_left_s1;
				right_q[0][PERM_IDX]  <= perm_left_s1;
				end_q[0][PERM_IDX]    <= perm_left_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule

FILE: hdl/double_ended_pool_allocator.sv
// Top level of the double-ended pool allocator: sequencer plus datapath.
`timescale 1ns / 1ps

// Each command has a capture cycle and an execute cycle: start is taken while
// busy is low, busy is then high for the execute cycle in which the selected
// pool (every pool, for init) is updated, and the result is registered onto
// the result port with done high for exactly one cycle, at which point a new
// command may already be taken. Every command, including init and ignored ones,
// produces exactly one result; the receiver cannot stall it and must capture it
// in that cycle. The capture cycle reads the pool tables and the execute cycle
// checks both banks and writes back. Configuration writes take effect at the
// edge where cfg_we is high and are used by the next init.
module double_ended_pool_allocator import dpa_pkg::*; #(
	parameter int POOL_COUNT = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  command_t    command,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output result_t     result
);

	dpa_ctl_t ctl;

	dpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	dpa_datapath #(
		.POOL_COUNT (POOL_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.command   (command),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule
